[rtl/sha1_with_extra_pad_block_macros.svh]
// assertion macros shared by the sha1 extra-pad block rtl
// used by files that carry concurrent checks; needs i_clk and i_rst_n in scope
`ifndef SHA1_WITH_EXTRA_PAD_BLOCK_MACROS_SVH
`define SHA1_WITH_EXTRA_PAD_BLOCK_MACROS_SVH

// checked only while out of reset
`define SXP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SXP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/sha1xp_pkg.sv]
// shared types and constants for the sha1 extra-pad block
// no dependencies
`default_nettype none

package sha1xp_pkg;

    localparam int unsigned ROUNDS = 80;
    localparam int unsigned WORDS  = 5;

    localparam logic [31:0] K_CH   = 32'h5A827999;
    localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [5:0] POS_LEN     = 6'd60;
    localparam logic [5:0] POS_BUG_LO  = 6'd52;
    localparam logic [5:0] POS_BUG_HI  = 6'd55;
    localparam logic [5:0] POS_TWO_BLK = 6'd56;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // register index decoded from paddr[2]
    localparam logic REG_PAD_BUG = 1'b0;

    typedef enum logic [2:0] {
        S_LOAD,
        S_COMP,
        S_FIN,
        S_PAD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR1,
        PH_MAJ,
        PH_PAR2
    } t_phase;

    typedef struct packed {
        logic   start;
        logic   step;
        logic   fin;
        logic   restart;
        t_phase phase;
    } t_rnd_ctl;

    typedef struct packed {
        logic shift;
        logic step;
    } t_sched_ctl;

    typedef logic [WORDS-1:0][31:0] t_chain;

    function automatic t_chain init_chain();
        t_chain c;
        c[0] = IV0;
        c[1] = IV1;
        c[2] = IV2;
        c[3] = IV3;
        c[4] = IV4;
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/sha1_with_extra_pad_block.sv]
// sha-1 byte stream hasher with optional extra zero pad block
// input: a byte is taken per cycle while loading; the 64th byte of a block holds input off while
// the block runs its 80 rounds on the shared round unit and then the chaining add
// last byte: pad bytes go in one per cycle, then each padded block (one or two blocks) is
// compressed before the first digest word leaves; words leave one per transfer
// reset: synchronous active low, chain to the initial vector, count to zero, bug enable to 1
`default_nettype none
`include "sha1_with_extra_pad_block_macros.svh"

module sha1_with_extra_pad_block (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,     // [7:0] data_byte
    input  wire logic        i_s_tlast,
    // digest stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,     // [31:0] digest_word
    output logic [2:0]       o_m_tuser,     // [2:0] word_index
    output logic             o_m_tlast,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    sha1xp_pkg::t_state r_state, n_state;
    logic [6:0]  r_round, n_round;
    logic [5:0]  r_pos, n_pos;
    logic [31:0] r_total, n_total;
    logic        r_in_pad, n_in_pad;
    logic        r_hold, n_hold;
    logic        r_mark, n_mark;
    logic        r_len_done, n_len_done;
    logic [2:0]  r_word, n_word;
    logic        r_bug;

    sha1xp_pkg::t_rnd_ctl   rnd_ctl;
    sha1xp_pkg::t_sched_ctl sch_ctl;
    sha1xp_pkg::t_chain     chain;
    logic [31:0] w;
    logic [7:0]  sch_byte, pad_byte;
    logic [31:0] bit_len;
    logic [5:0]  end_pos;
    logic        in_xfer, out_xfer;

    // register port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bug <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == sha1xp_pkg::REG_PAD_BUG) begin
            r_bug <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == sha1xp_pkg::REG_PAD_BUG) ? {31'd0, r_bug} : 32'd0;

    sha1xp_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (sch_ctl),
        .i_byte (sch_byte),
        .o_w    (w)
    );

    sha1xp_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rnd_ctl),
        .i_w     (w),
        .o_chain (chain)
    );

    assign o_s_tready = (r_state == sha1xp_pkg::S_LOAD);
    assign o_m_tvalid = (r_state == sha1xp_pkg::S_OUT);
    assign o_m_tdata  = chain[r_word];
    assign o_m_tuser  = r_word;
    assign o_m_tlast  = (r_word == 3'(sha1xp_pkg::WORDS - 1));
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign out_xfer   = o_m_tvalid && i_m_tready;

    assign bit_len = {r_total[28:0], 3'b000};
    assign end_pos = r_pos + 6'd1;

    // pad stream: marker, zeros, then the length unless this block is held back
    always_comb begin
        if (!r_mark) begin
            pad_byte = sha1xp_pkg::PAD_MARK;
        end else if (r_pos < sha1xp_pkg::POS_LEN || r_hold) begin
            pad_byte = 8'h00;
        end else begin
            case (r_pos[1:0])
                2'd0:    pad_byte = bit_len[31:24];
                2'd1:    pad_byte = bit_len[23:16];
                2'd2:    pad_byte = bit_len[15:8];
                default: pad_byte = bit_len[7:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha1xp_pkg::S_LOAD;
            r_round    <= '0;
            r_pos      <= '0;
            r_total    <= '0;
            r_in_pad   <= 1'b0;
            r_hold     <= 1'b0;
            r_mark     <= 1'b0;
            r_len_done <= 1'b0;
            r_word     <= '0;
        end else begin
            r_state    <= n_state;
            r_round    <= n_round;
            r_pos      <= n_pos;
            r_total    <= n_total;
            r_in_pad   <= n_in_pad;
            r_hold     <= n_hold;
            r_mark     <= n_mark;
            r_len_done <= n_len_done;
            r_word     <= n_word;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_round    = r_round;
        n_pos      = r_pos;
        n_total    = r_total;
        n_in_pad   = r_in_pad;
        n_hold     = r_hold;
        n_mark     = r_mark;
        n_len_done = r_len_done;
        n_word     = r_word;
        sch_byte   = i_s_tdata;
        sch_ctl    = '0;
        rnd_ctl    = '0;

        if (r_round < 7'd20) begin
            rnd_ctl.phase = sha1xp_pkg::PH_CH;
        end else if (r_round < 7'd40) begin
            rnd_ctl.phase = sha1xp_pkg::PH_PAR1;
        end else if (r_round < 7'd60) begin
            rnd_ctl.phase = sha1xp_pkg::PH_MAJ;
        end else begin
            rnd_ctl.phase = sha1xp_pkg::PH_PAR2;
        end

        unique case (r_state)
            sha1xp_pkg::S_LOAD: begin
                if (in_xfer) begin
                    sch_ctl.shift = 1'b1;
                    n_pos   = end_pos;
                    n_total = r_total + 32'd1;
                    if (i_s_tlast) begin
                        n_in_pad = 1'b1;
                        n_mark   = 1'b0;
                        // length lands in a later block if no room, or bug mode and end 52..55
                        n_hold   = (end_pos >= sha1xp_pkg::POS_TWO_BLK)
                                || (r_bug && end_pos >= sha1xp_pkg::POS_BUG_LO
                                          && end_pos <= sha1xp_pkg::POS_BUG_HI);
                    end
                    if (r_pos == 6'd63) begin
                        rnd_ctl.start = 1'b1;
                        n_state = sha1xp_pkg::S_COMP;
                    end else if (i_s_tlast) begin
                        n_state = sha1xp_pkg::S_PAD;
                    end
                end
            end
            sha1xp_pkg::S_PAD: begin
                sch_ctl.shift = 1'b1;
                sch_byte = pad_byte;
                n_mark   = 1'b1;
                n_pos    = end_pos;
                if (r_pos == 6'd63) begin
                    n_len_done    = r_mark && !r_hold;
                    n_hold        = 1'b0;
                    rnd_ctl.start = 1'b1;
                    n_state       = sha1xp_pkg::S_COMP;
                end
            end
            sha1xp_pkg::S_COMP: begin
                sch_ctl.step = 1'b1;
                rnd_ctl.step = 1'b1;
                if (r_round == 7'(sha1xp_pkg::ROUNDS - 1)) begin
                    n_round = '0;
                    n_state = sha1xp_pkg::S_FIN;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            sha1xp_pkg::S_FIN: begin
                rnd_ctl.fin = 1'b1;
                if (r_len_done) begin
                    n_word  = '0;
                    n_state = sha1xp_pkg::S_OUT;
                end else if (r_in_pad) begin
                    n_state = sha1xp_pkg::S_PAD;
                end else begin
                    n_state = sha1xp_pkg::S_LOAD;
                end
            end
            sha1xp_pkg::S_OUT: begin
                if (out_xfer) begin
                    if (o_m_tlast) begin
                        rnd_ctl.restart = 1'b1;
                        n_total    = '0;
                        n_pos      = '0;
                        n_in_pad   = 1'b0;
                        n_hold     = 1'b0;
                        n_mark     = 1'b0;
                        n_len_done = 1'b0;
                        n_word     = '0;
                        n_state    = sha1xp_pkg::S_LOAD;
                    end else begin
                        n_word = r_word + 3'd1;
                    end
                end
            end
            default: begin
                n_state = sha1xp_pkg::S_LOAD;
            end
        endcase
    end

    `SXP_ASSERT(a_restart_clears, (out_xfer && o_m_tlast) |=> (r_total == 32'd0 && r_pos == 6'd0 && !r_in_pad), "state not cleared after digest")
    `SXP_ASSERT(a_fin_after_rounds, (r_state == sha1xp_pkg::S_FIN) |-> ($past(r_state) == sha1xp_pkg::S_COMP && $past(r_round) == 7'(sha1xp_pkg::ROUNDS - 1)), "chain add without full round count")
    `SXP_ASSERT(a_no_input_in_pad, o_s_tready |-> !r_in_pad, "input taken while padding")
    `SXP_ASSERT(a_len_only_in_pad, r_len_done |-> (r_in_pad && r_mark), "length written outside padding")
    `SXP_ASSERT_ALWAYS(a_word_range, o_m_tvalid |-> (r_word < 3'(sha1xp_pkg::WORDS)), "digest word index out of range")

endmodule

`default_nettype wire

[rtl/sha1xp_sched.sv]
// message window: bytes shift in, then the sha-1 word expansion runs in place
// depends on sha1xp_pkg
`default_nettype none

module sha1xp_sched (
    input  wire logic                  i_clk,
    input  wire sha1xp_pkg::t_sched_ctl i_ctl,
    input  wire logic [7:0]            i_byte,
    output logic [31:0]                o_w
);

    logic [31:0] r_s [16];
    logic [31:0] expd;

    always_comb begin
        expd = r_s[13] ^ r_s[8] ^ r_s[2] ^ r_s[0];
        expd = {expd[30:0], expd[31]};
    end

    assign o_w = r_s[0];

    // r_s[0] holds the oldest word; the expanded word enters at the top
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int i = 0; i < 15; i++) begin
                r_s[i] <= {r_s[i][23:0], r_s[i+1][31:24]};
            end
            r_s[15] <= {r_s[15][23:0], i_byte};
        end else if (i_ctl.step) begin
            for (int i = 0; i < 15; i++) begin
                r_s[i] <= r_s[i+1];
            end
            r_s[15] <= expd;
        end
    end

endmodule

`default_nettype wire

[rtl/sha1xp_round.sv]
// sha-1 round unit: one round per cycle on a..e while step is set, plus the chaining words
// depends on sha1xp_pkg
`default_nettype none

module sha1xp_round (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sha1xp_pkg::t_rnd_ctl i_ctl,
    input  wire logic [31:0]          i_w,
    output sha1xp_pkg::t_chain        o_chain
);

    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    sha1xp_pkg::t_chain r_h;
    logic [31:0] f, k, t;

    always_comb begin
        case (i_ctl.phase)
            sha1xp_pkg::PH_CH: begin
                f = (r_b & r_c) | (~r_b & r_d);
                k = sha1xp_pkg::K_CH;
            end
            sha1xp_pkg::PH_PAR1: begin
                f = r_b ^ r_c ^ r_d;
                k = sha1xp_pkg::K_PAR1;
            end
            sha1xp_pkg::PH_MAJ: begin
                f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
                k = sha1xp_pkg::K_MAJ;
            end
            default: begin
                f = r_b ^ r_c ^ r_d;
                k = sha1xp_pkg::K_PAR2;
            end
        endcase
        t = {r_a[26:0], r_a[31:27]} + f + r_e + k + i_w;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_ctl.step) begin
            r_a <= t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= sha1xp_pkg::init_chain();
        end else if (i_ctl.restart) begin
            r_h <= sha1xp_pkg::init_chain();
        end else if (i_ctl.fin) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e;
        end
    end

    assign o_chain = r_h;

endmodule

`default_nettype wire

[verif/testbench.sv]
// self-checking testbench for sha1_with_extra_pad_block: byte stream in, digest words out
// carries its own sha-1 predictor with the extra pad block; needs sha1xp_pkg and the rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned IDLE_PCT    = 24;
    localparam int unsigned PHASE_ITEMS = 60;
    localparam int unsigned DRAIN_WAIT  = 100;
    localparam int unsigned END_WAIT    = 300;

    // register addresses: index in paddr[2]
    localparam logic [2:0] ADDR_PAD_BUG = {sha1xp_pkg::REG_PAD_BUG, 2'b00};
    localparam logic [2:0] ADDR_SPARE   = {~sha1xp_pkg::REG_PAD_BUG, 2'b00};

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    typedef struct packed {
        logic [7:0]   data;
        logic         last;
        logic         known;
        logic [159:0] digest;
    } t_stim_row;

    localparam t_stim_row DIRECTED [0:8] = '{
        '{8'h61, 1'b0, 1'b0, 160'h0},
        '{8'h62, 1'b0, 1'b0, 160'h0},
        '{8'h63, 1'b1, 1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d},
        '{8'h00, 1'b1, 1'b0, 160'h0},
        '{8'hFF, 1'b1, 1'b0, 160'h0},
        '{8'h00, 1'b0, 1'b0, 160'h0},
        '{8'hFF, 1'b0, 1'b0, 160'h0},
        '{8'hAA, 1'b0, 1'b0, 160'h0},
        '{8'h55, 1'b1, 1'b0, 160'h0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;     // [7:0] data_byte
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;             // [31:0] digest_word
    logic [2:0]  o_m_tuser;             // [2:0] word_index
    logic        o_m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [31:0] hash_chain [5];
    logic [7:0]  block_buf [64];
    logic [31:0] msg_len;
    logic        pad_bug_en;

    t_digest_word digest_q [$];
    t_digest_word want;
    int unsigned  mismatch_count = 0;
    int unsigned  cycles = 0;
    int unsigned  hold_req = 0;
    int unsigned  hold_seen = 0;
    int unsigned  hold_left = 0;
    logic         tx_calm = 1'b0;

    sha1_with_extra_pad_block dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void restart_hash();
        hash_chain[0] = sha1xp_pkg::IV0;
        hash_chain[1] = sha1xp_pkg::IV1;
        hash_chain[2] = sha1xp_pkg::IV2;
        hash_chain[3] = sha1xp_pkg::IV3;
        hash_chain[4] = sha1xp_pkg::IV4;
        msg_len = 32'd0;
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, nw;
        for (int i = 0; i < 16; i++)
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        e = hash_chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 16) begin
                nw = w[r];
            end else begin
                nw = w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16];
                nw = {nw[30:0], nw[31]};
                w[r%16] = nw;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = sha1xp_pkg::K_CH;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = sha1xp_pkg::K_PAR1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1xp_pkg::K_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = sha1xp_pkg::K_PAR2;
            end
            t = {a[26:0], a[31:27]} + f + e + k + nw;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        hash_chain[4] += e;
    endfunction

    // returns 1 when the byte closes a message and words holds the digest
    function automatic logic absorb_byte(input logic [7:0] data, input logic last,
                                         output logic [31:0] words [5]);
        int unsigned pos;
        logic [31:0] bit_len;
        logic        extra;
        block_buf[msg_len[5:0]] = data;
        msg_len = msg_len + 1;
        if (msg_len[5:0] == 6'd0)
            sha_compress();
        if (!last)
            return 1'b0;
        pos = msg_len[5:0];
        bit_len = msg_len << 3;
        extra = pad_bug_en && pos >= sha1xp_pkg::POS_BUG_LO
                && pos <= sha1xp_pkg::POS_BUG_HI;
        block_buf[pos] = sha1xp_pkg::PAD_MARK;
        if (pos >= sha1xp_pkg::POS_TWO_BLK) begin
            for (int j = pos + 1; j < 64; j++)
                block_buf[j] = 8'h00;
            sha_compress();
            for (int j = 0; j < sha1xp_pkg::POS_LEN; j++)
                block_buf[j] = 8'h00;
        end else begin
            for (int j = pos + 1; j < sha1xp_pkg::POS_LEN; j++)
                block_buf[j] = 8'h00;
        end
        // bug mode: zeros where the length belongs, then a whole extra block
        if (extra) begin
            for (int j = sha1xp_pkg::POS_LEN; j < 64; j++)
                block_buf[j] = 8'h00;
            sha_compress();
            for (int j = 0; j < sha1xp_pkg::POS_LEN; j++)
                block_buf[j] = 8'h00;
        end
        block_buf[60] = bit_len[31:24];
        block_buf[61] = bit_len[23:16];
        block_buf[62] = bit_len[15:8];
        block_buf[63] = bit_len[7:0];
        sha_compress();
        for (int i = 0; i < 5; i++)
            words[i] = hash_chain[i];
        restart_hash();
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic last,
                             input logic have_known, input logic [159:0] known);
        logic [31:0]  words [5];
        t_digest_word entry;
        if (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        if (absorb_byte(data, last, words)) begin
            for (int i = 0; i < 5; i++) begin
                entry.word  = have_known ? known[159 - 32*i -: 32] : words[i];
                entry.index = 3'(i);
                entry.last  = (i == 4);
                digest_q.push_back(entry);
            end
        end
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1, 1'b0, 160'h0);
    endtask

    function automatic int unsigned pick_length();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return $urandom_range(1, 12);
        else if (sel < 70)
            return $urandom_range(sha1xp_pkg::POS_BUG_LO, sha1xp_pkg::POS_BUG_HI);
        else if (sel < 85)
            return $urandom_range(sha1xp_pkg::POS_TWO_BLK, 64);
        else
            return $urandom_range(65, 130);
    endfunction

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (digest_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr[2] == sha1xp_pkg::REG_PAD_BUG)
            pad_bug_en = data[0];
        @(posedge i_clk);
    endtask

    task automatic apb_check_pad_bug();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_PAD_BUG;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {31'd0, pad_bug_en}) begin
            $display("%0t pad bug register: expected %h got %h",
                     $time, {31'd0, pad_bug_en}, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input logic hold_off, input logic drain_pause);
        int unsigned start_len;
        int unsigned msgs;
        int unsigned len;
        start_len = 0;
        msgs = 0;
        while (start_len < PHASE_ITEMS) begin
            if (msgs == 0)
                len = $urandom_range(1, 12);
            else if (msgs == 1)
                len = $urandom_range(sha1xp_pkg::POS_BUG_LO, sha1xp_pkg::POS_BUG_HI);
            else if (msgs == 2)
                len = $urandom_range(sha1xp_pkg::POS_TWO_BLK, 64);
            else
                len = pick_length();
            // receiver stalls while the following message keeps coming
            if (hold_off && msgs == 0) begin
                hold_req <= hold_req + 1;
                len = 3;
            end
            if (drain_pause && msgs == 1)
                wait_drained();
            send_message(len);
            start_len += len;
            msgs++;
        end
    endtask

    // digest receiver: random stalls, one calm window, one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen  <= hold_req;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (cycles >= 1500 && cycles < 3000) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (digest_q.size() == 0) begin
                $display("%0t unexpected digest transfer: got word %h index %0d last %b",
                         $time, o_m_tdata, o_m_tuser, o_m_tlast);
                mismatch_count++;
            end else begin
                want = digest_q.pop_front();
                if (o_m_tdata !== want.word) begin
                    $display("%0t digest word: expected %h got %h", $time, want.word, o_m_tdata);
                    mismatch_count++;
                end
                if (o_m_tuser !== want.index) begin
                    $display("%0t word index: expected %0d got %0d",
                             $time, want.index, o_m_tuser);
                    mismatch_count++;
                end
                if (o_m_tlast !== want.last) begin
                    $display("%0t last word: expected %b got %b", $time, want.last, o_m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        restart_hash();
        for (int i = 0; i < 64; i++)
            block_buf[i] = 8'h00;
        pad_bug_en = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value, then a write to the unused index must change nothing
        apb_check_pad_bug();
        apb_write(ADDR_SPARE, 32'd0);
        apb_check_pad_bug();

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].known, DIRECTED[i].digest);

        run_phase(1'b1, 1'b0);

        settle();
        apb_write(ADDR_PAD_BUG, 32'd0);
        apb_check_pad_bug();
        tx_calm = 1'b1;
        run_phase(1'b0, 1'b1);
        tx_calm = 1'b0;

        settle();
        apb_write(ADDR_PAD_BUG, 32'hFFFF_FFFF);
        apb_check_pad_bug();
        run_phase(1'b0, 1'b0);

        wait_drained();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
